// File: hw/rtl/imuftc_pkg.sv
package imuftc_pkg;

	// Frame bytes.
	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] KIND_ACCEL = 8'h51;
	localparam logic [7:0] KIND_GYRO  = 8'h52;
	localparam logic [7:0] KIND_ANGLE = 8'h53;

	// Configuration port layout.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_EN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_BIAS = 1'd1;
	localparam logic [CFG_DATA_W-1:0] BIAS_RESET   = 14'd1820;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_NONE,
		ST_YAW,
		ST_CKSUM,
		ST_OTHER,
		ST_BAD_TYPE
	} status_t;

	// What the parser reports for one byte.
	typedef struct packed {
		status_t            status;
		logic               yaw_ok;
		logic signed [15:0] yaw;
	} parse_res_t;

endpackage

// File: hw/rtl/imuftc_if.sv
interface imuftc_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;

	modport source (output valid, func, rx_byte, input ready);
	modport sink (input valid, func, rx_byte, output ready);
endinterface

interface imuftc_out_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  status;
	logic signed [15:0] yaw_angle;
	logic signed [31:0] total_angle;
	logic        [17:0] quarter_turns;
	logic signed [32:0] target_angle;

	modport source (output valid, status, yaw_angle, total_angle, quarter_turns, target_angle,
		input ready);
	modport sink (input valid, status, yaw_angle, total_angle, quarter_turns, target_angle,
		output ready);
endinterface

// File: hw/rtl/imuftc_parser.sv
module imuftc_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_en,
	input  logic [7:0]              rx_byte,
	output imuftc_pkg::parse_res_t  res
);
	import imuftc_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_TYPE,
		PH_PAYLOAD
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [3:0] count_q, count_n;
	logic [7:0] kind_q, kind_n;
	logic [7:0] sum_q, sum_n;
	logic [7:0] ylo_q, ylo_n;
	logic [7:0] yhi_q, yhi_n;

	// Next parser state and the status for the byte on the input.
	always_comb begin
		phase_n    = phase_q;
		count_n    = count_q;
		kind_n     = kind_q;
		sum_n      = sum_q;
		ylo_n      = ylo_q;
		yhi_n      = yhi_q;
		res.status = ST_NONE;
		res.yaw_ok = 1'b0;
		res.yaw    = {yhi_q, ylo_q};
		case (phase_q)
			PH_HEADER: begin
				if (rx_byte == HDR_BYTE) begin
					sum_n   = HDR_BYTE;
					phase_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (rx_byte inside {KIND_ACCEL, KIND_GYRO, KIND_ANGLE}) begin
					kind_n  = rx_byte;
					sum_n   = sum_q + rx_byte;
					count_n = 4'd0;
					phase_n = PH_PAYLOAD;
				end else begin
					res.status = ST_BAD_TYPE;
					// A header byte in the type slot starts a new frame.
					if (rx_byte == HDR_BYTE) begin
						sum_n   = HDR_BYTE;
						phase_n = PH_TYPE;
					end else begin
						phase_n = PH_HEADER;
					end
				end
			end
			PH_PAYLOAD: begin
				if (count_q == 4'd4) ylo_n = rx_byte;
				if (count_q == 4'd5) yhi_n = rx_byte;
				if (count_q < 4'd8) begin
					sum_n   = sum_q + rx_byte;
					count_n = count_q + 4'd1;
				end else begin
					// This byte is the checksum.
					count_n = 4'd0;
					phase_n = PH_HEADER;
					if (kind_q == KIND_ANGLE) begin
						if (sum_q == rx_byte) begin
							res.status = ST_YAW;
							res.yaw_ok = 1'b1;
						end else begin
							res.status = ST_CKSUM;
						end
					end else begin
						res.status = ST_OTHER;
					end
				end
			end
			default: begin
				count_n = 4'd0;
				phase_n = PH_HEADER;
			end
		endcase
	end

	// Parser state advances once per received byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= 4'd0;
			kind_q  <= 8'd0;
			sum_q   <= 8'd0;
			ylo_q   <= 8'd0;
			yhi_q   <= 8'd0;
		end else if (byte_en) begin
			phase_q <= phase_n;
			count_q <= count_n;
			kind_q  <= kind_n;
			sum_q   <= sum_n;
			ylo_q   <= ylo_n;
			yhi_q   <= yhi_n;
		end
	end

endmodule

// File: hw/rtl/imu_frame_parser_turn_counter.sv
// Channel   Dir  Payload                                                  Handshake
// rx_items  in   func, rx_byte                                            valid/ready
// results   out  status, yaw_angle, total_angle, quarter_turns, target   valid/ready
// cfg       in   cfg_we, cfg_index, cfg_wdata                             write enable only
//
// Three register stages: input, frame parse and total update, turn count.
// One request is taken per cycle while the results channel does not stall; each passes the
// input, stage-two and result registers. The rate is set by the total update, which closes on itself.
// A stalled result holds the whole pipe; ready reaches the input combinationally.
// Reset clears the parser, the totals and the pipe; no clearing pass is needed.
module imu_frame_parser_turn_counter #(
	parameter int TOTAL_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [imuftc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imuftc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	imuftc_in_if.sink                          rx_items,
	imuftc_out_if.source                       results
);
	import imuftc_pkg::*;

	localparam int TW = TOTAL_WIDTH;
	localparam int SW = TOTAL_WIDTH + 1;
	localparam int QW = TOTAL_WIDTH - 13;
	localparam int EW = TOTAL_WIDTH + 34;
	localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
	localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};

	// Configuration registers.
	logic                  count_en_q;
	logic [CFG_DATA_W-1:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_en_q <= 1'b0;
			bias_q     <= BIAS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUNT_EN:  count_en_q <= cfg_wdata[0];
				CFG_TURN_BIAS: bias_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline flow control.
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	assign adv3           = !valid_s3 || results.ready;
	assign adv2           = !valid_s2 || adv3;
	assign adv1           = !valid_s1 || adv2;
	assign rx_items.ready = adv1;

	// Input register.
	logic       func_s1;
	logic [7:0] byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= rx_items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			func_s1 <= rx_items.func;
			byte_s1 <= rx_items.rx_byte;
		end
	end

	// Frame parser, stepped by each byte request that enters stage two.
	logic       take;
	logic       byte_en;
	parse_res_t pres;

	assign take    = valid_s1 && adv2;
	assign byte_en = take && !func_s1;

	imuftc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.rx_byte (byte_s1),
		.res     (pres)
	);

	// Yaw difference, wrapped to a half turn, and the saturating total.
	logic signed [15:0] cur_yaw_q, prev_yaw_q;
	logic signed [TW-1:0] total_q;
	logic signed [17:0] diff_raw, diff_wrap;
	logic signed [SW-1:0] tot_sum;
	logic signed [TW-1:0] tot_sat;

	always_comb begin
		diff_raw = 18'(pres.yaw) - 18'(prev_yaw_q);
		if (diff_raw < -18'sd32768) begin
			diff_wrap = diff_raw + 18'sd65536;
		end else if (diff_raw > 18'sd32768) begin
			diff_wrap = diff_raw - 18'sd65536;
		end else begin
			diff_wrap = diff_raw;
		end
		tot_sum = SW'(total_q) + SW'(diff_wrap);
		if (tot_sum[SW-1] != tot_sum[SW-2]) begin
			tot_sat = tot_sum[SW-1] ? T_MIN : T_MAX;
		end else begin
			tot_sat = tot_sum[TW-1:0];
		end
	end

	// Stage two: yaw and total state, with the status of the request.
	status_t status_s2;
	logic    upd_s2, clr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			cur_yaw_q  <= '0;
			prev_yaw_q <= '0;
			total_q    <= '0;
		end else begin
			if (adv2) valid_s2 <= valid_s1;
			if (take && func_s1) begin
				total_q    <= '0;
				prev_yaw_q <= cur_yaw_q;
			end else if (byte_en && pres.yaw_ok) begin
				cur_yaw_q  <= pres.yaw;
				prev_yaw_q <= pres.yaw;
				if (count_en_q) total_q <= tot_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_s2 <= func_s1 ? ST_NONE : pres.status;
			upd_s2    <= !func_s1 && pres.yaw_ok && count_en_q;
			clr_s2    <= func_s1;
		end
	end

	// Quarter turns and target from the stage-two total.
	logic          [TW-1:0] tot_u, mag;
	logic          [SW-1:0] biased;
	logic          [QW-1:0] quarters;
	logic          [EW-1:0] q_ext, tgt_pos, tgt;
	logic signed   [EW-1:0] tot_ext;

	always_comb begin
		tot_u    = total_q;
		mag      = total_q[TW-1] ? (~tot_u + TW'(1)) : tot_u;
		biased   = SW'(mag) + SW'(bias_q);
		quarters = biased[SW-1:14];
		q_ext    = EW'(quarters);
		tgt_pos  = q_ext << 14;
		tgt      = total_q[TW-1] ? (~tgt_pos + EW'(1)) : tgt_pos;
		tot_ext  = EW'(total_q);
	end

	// Stage three: result register; turn count and target are kept state.
	logic                load3;
	status_t             status_s3;
	logic signed [15:0]  yaw_s3;
	logic signed [31:0]  total_s3;
	logic        [17:0]  turn_q;
	logic signed [32:0]  target_q;

	assign load3 = valid_s2 && adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			turn_q   <= '0;
			target_q <= '0;
		end else begin
			if (adv3) valid_s3 <= valid_s2;
			if (load3 && clr_s2) begin
				turn_q   <= '0;
				target_q <= '0;
			end else if (load3 && upd_s2) begin
				turn_q   <= q_ext[17:0];
				target_q <= tgt[32:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load3) begin
			status_s3 <= status_s2;
			yaw_s3    <= cur_yaw_q;
			total_s3  <= tot_ext[31:0];
		end
	end

	assign results.valid         = valid_s3;
	assign results.status        = status_s3;
	assign results.yaw_angle     = yaw_s3;
	assign results.total_angle   = total_s3;
	assign results.quarter_turns = turn_q;
	assign results.target_angle  = target_q;

	// A clear request leaves no turns behind.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load3 && clr_s2 |=> turn_q == '0 && target_q == '0)
		else $error("turn state not cleared");

	// The target is always a whole number of quarter turns.
	a_target_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		target_q[13:0] == 14'd0)
		else $error("target not quarter-turn aligned");

	// The total moves only when a request enters stage two.
	a_total_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(total_q))
		else $error("total changed without a request");

endmodule
